@@ hdl/aekp_pkg.sv @@
// ----------------------------------------------------------------------------
// aekp_pkg: shared types and constants for the terminal escape-key parser
// Parser states, result kinds, character constants and small decode helpers.
// ----------------------------------------------------------------------------
package aekp_pkg;

    localparam int unsigned QUEUE_DEPTH = 5;
    localparam int unsigned COUNT_W     = 3;

    localparam logic [7:0] QUIT_RESET = 8'h1D;
    localparam logic [7:0] CH_ESC     = 8'h1B;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;   // '['
    localparam logic [7:0] CH_SS3     = 8'h4F;   // 'O'
    localparam logic [7:0] CH_TILDE   = 8'h7E;   // '~'
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_A       = 8'h41;
    localparam logic [7:0] CH_D       = 8'h44;
    localparam logic [7:0] CH_P       = 8'h50;
    localparam logic [7:0] CH_S       = 8'h53;

    localparam logic [6:0] NUM_MAX    = 7'd99;

    typedef enum logic [2:0] {
        ST_IDLE = 3'd0,
        ST_ESC  = 3'd1,
        ST_CSI  = 3'd2,
        ST_NUM  = 3'd3,
        ST_SS3  = 3'd4
    } state_t;

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_KEY   = 2'd1,
        KIND_QUIT  = 2'd2
    } kind_t;

    localparam logic [3:0] KEY_F1 = 4'd4;
    localparam logic [3:0] KEY_F6 = 4'd9;
    localparam logic [3:0] KEY_F11 = 4'd14;
    localparam logic [3:0] KEY_F12 = 4'd15;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] plain_byte;
        logic [3:0] key_code;
    } res_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] key_code;
    } fkey_t;

    function automatic res_t mk_plain(input logic [7:0] b);
        res_t r;
        r.kind       = KIND_PLAIN;
        r.plain_byte = b;
        r.key_code   = 4'd0;
        return r;
    endfunction

    function automatic res_t mk_key(input logic [3:0] k);
        res_t r;
        r.kind       = KIND_KEY;
        r.plain_byte = 8'd0;
        r.key_code   = k;
        return r;
    endfunction

    function automatic res_t mk_quit();
        res_t r;
        r.kind       = KIND_QUIT;
        r.plain_byte = 8'd0;
        r.key_code   = 4'd0;
        return r;
    endfunction

    // Map the number of an ESC [ n ~ sequence to a function key.
    function automatic fkey_t fkey_decode(input logic [6:0] n);
        fkey_t f;
        f.hit      = 1'b1;
        f.key_code = 4'd0;
        case (n) inside
            [7'd11:7'd15]: f.key_code = KEY_F1 + 4'(n - 7'd11);
            [7'd17:7'd21]: f.key_code = KEY_F6 + 4'(n - 7'd17);
            7'd23:         f.key_code = KEY_F11;
            7'd24:         f.key_code = KEY_F12;
            default:       f.hit      = 1'b0;
        endcase
        return f;
    endfunction

endpackage

@@ hdl/ansi_escape_key_parser.sv @@
// ----------------------------------------------------------------------------
// ansi_escape_key_parser: terminal byte stream to keys
// Parses ESC sequences into arrow and function keys, passes other bytes on.
// ----------------------------------------------------------------------------
// One terminal byte is taken per request on the input channel and decoded
// combinationally into zero to five results, which are loaded into a five-deep
// result queue and drained on the output channel one per cycle while out_ready
// is high. As a byte that yields zero or one result does not hold the input, an
// ordinary stream runs at one byte per clock while the output is ready, with a
// new byte accepted while the previous result is being taken. A broken sequence
// flushes its swallowed bytes as plain bytes; a flush holds the input while the
// queue drains, since a new byte is accepted only once the queue empties in that cycle.
// Results: kind 0 plain byte, 1 special key (0..3 arrows up/down/right/left,
// 4..15 F1..F12), 2 quit request; last marks the final result of a byte.
// The quit byte (reset 0x1D) is written through the cfg channel, which is
// always ready; write it only while the block is idle.
// ----------------------------------------------------------------------------
module ansi_escape_key_parser
    import aekp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] quit_byte,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,

    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] plain_byte,
    output logic [3:0] key_code,
    output logic       last
);

    // Configuration and parser state
    logic [7:0]         quit_reg;
    state_t             state_reg, state_next;
    logic [6:0]         acc_reg, acc_next;

    // Result queue: entry 0 is the head shown on the output
    res_t               q_reg  [QUEUE_DEPTH];
    res_t               q_next [QUEUE_DEPTH];
    res_t               build  [QUEUE_DEPTH];
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [COUNT_W-1:0] n_res;

    logic               accept;
    logic               pop;

    // Decode helpers
    logic               is_digit;
    logic [3:0]         digit_val;
    logic [6:0]         acc_sat;
    logic [9:0]         acc_times10;
    logic [6:0]         acc_grown;
    logic [14:0]        tens_prod;
    logic [3:0]         tens;
    logic [3:0]         ones;
    fkey_t              fkey;

    // ------------------------------------------------------------------
    // Handshakes: take a byte whenever the queue is empty by the end of
    // this cycle
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && out_ready;
    assign in_ready  = (count_reg == '0) || ((count_reg == COUNT_W'(1)) && out_ready);
    assign accept    = in_valid && in_ready;

    assign kind       = q_reg[0].kind;
    assign plain_byte = q_reg[0].plain_byte;
    assign key_code   = q_reg[0].key_code;
    assign last       = (count_reg == COUNT_W'(1));

    // ------------------------------------------------------------------
    // Number arithmetic: accumulate with saturation, split into digits
    // ------------------------------------------------------------------
    assign is_digit    = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
    assign digit_val   = in_byte[3:0];
    assign acc_sat     = (acc_reg > NUM_MAX) ? NUM_MAX : acc_reg;
    assign acc_times10 = ({3'b000, acc_sat} << 3) + ({3'b000, acc_sat} << 1)
                         + {6'b000000, digit_val};
    assign acc_grown   = (acc_times10 > {3'b000, NUM_MAX}) ? NUM_MAX : acc_times10[6:0];

    // acc / 10 by reciprocal: exact for every value up to 99
    assign tens_prod   = 15'(acc_sat) * 15'd205;
    assign tens        = tens_prod[14:11];
    assign ones        = 4'(acc_sat - {tens, 3'b000} - {2'b00, tens, 1'b0});

    assign fkey        = fkey_decode(acc_sat);

    // ------------------------------------------------------------------
    // Next state for the parser
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        if (in_byte != quit_reg)
        begin
            unique case (state_reg)
                ST_ESC:
                begin
                    if (in_byte == CH_LBRACK)
                        state_next = ST_CSI;
                    else if (in_byte == CH_SS3)
                        state_next = ST_SS3;
                    else
                        state_next = ST_IDLE;
                end
                ST_CSI:
                begin
                    if (is_digit && !((in_byte >= CH_A) && (in_byte <= CH_D)))
                    begin
                        state_next = ST_NUM;
                        acc_next   = {3'b000, digit_val};
                    end
                    else
                        state_next = ST_IDLE;
                end
                ST_NUM:
                begin
                    if (is_digit)
                        acc_next = acc_grown;
                    else
                        state_next = ST_IDLE;
                end
                ST_SS3:
                    state_next = ST_IDLE;
                default:
                    state_next = (in_byte == CH_ESC) ? ST_ESC : ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Results for the incoming byte
    // ------------------------------------------------------------------
    always_comb
    begin
        n_res = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            build[i] = mk_plain(8'd0);

        if (in_byte == quit_reg)
        begin
            build[0] = mk_quit();
            n_res    = COUNT_W'(1);
        end
        else
        begin
            unique case (state_reg)
                ST_ESC:
                begin
                    if ((in_byte != CH_LBRACK) && (in_byte != CH_SS3))
                    begin
                        build[0] = mk_plain(CH_ESC);
                        build[1] = mk_plain(in_byte);
                        n_res    = COUNT_W'(2);
                    end
                end
                ST_CSI:
                begin
                    if ((in_byte >= CH_A) && (in_byte <= CH_D))
                    begin
                        build[0] = mk_key(4'(in_byte - CH_A));
                        n_res    = COUNT_W'(1);
                    end
                    else if (!is_digit)
                    begin
                        build[0] = mk_plain(CH_ESC);
                        build[1] = mk_plain(CH_LBRACK);
                        build[2] = mk_plain(in_byte);
                        n_res    = COUNT_W'(3);
                    end
                end
                ST_NUM:
                begin
                    if (in_byte == CH_TILDE)
                    begin
                        // drop numbers that name no function key
                        if (fkey.hit)
                        begin
                            build[0] = mk_key(fkey.key_code);
                            n_res    = COUNT_W'(1);
                        end
                    end
                    else if (!is_digit)
                    begin
                        build[0] = mk_plain(CH_ESC);
                        build[1] = mk_plain(CH_LBRACK);
                        if (tens != 4'd0)
                        begin
                            build[2] = mk_plain({4'h3, tens});
                            build[3] = mk_plain({4'h3, ones});
                            build[4] = mk_plain(in_byte);
                            n_res    = COUNT_W'(5);
                        end
                        else
                        begin
                            build[2] = mk_plain({4'h3, ones});
                            build[3] = mk_plain(in_byte);
                            n_res    = COUNT_W'(4);
                        end
                    end
                end
                ST_SS3:
                begin
                    if ((in_byte >= CH_P) && (in_byte <= CH_S))
                    begin
                        build[0] = mk_key(4'(in_byte - CH_P) + KEY_F1);
                        n_res    = COUNT_W'(1);
                    end
                    else
                    begin
                        build[0] = mk_plain(CH_ESC);
                        build[1] = mk_plain(CH_SS3);
                        build[2] = mk_plain(in_byte);
                        n_res    = COUNT_W'(3);
                    end
                end
                default:
                begin
                    if (in_byte != CH_ESC)
                    begin
                        build[0] = mk_plain(in_byte);
                        n_res    = COUNT_W'(1);
                    end
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Queue: load on a new byte, else advance the head on each pop
    // ------------------------------------------------------------------
    always_comb
    begin
        count_next = count_reg;
        for (int i = 0; i < QUEUE_DEPTH; i++)
            q_next[i] = q_reg[i];

        if (accept)
        begin
            count_next = n_res;
            for (int i = 0; i < QUEUE_DEPTH; i++)
                q_next[i] = build[i];
        end
        else if (pop)
        begin
            count_next = count_reg - COUNT_W'(1);
            for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                q_next[i] = q_reg[i + 1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quit_reg  <= QUIT_RESET;
            state_reg <= ST_IDLE;
            acc_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                quit_reg <= quit_byte;
            if (accept)
            begin
                state_reg <= state_next;
                acc_reg   <= acc_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
            q_reg[i] <= q_next[i];
    end

endmodule

@@ test/tb_ansi_escape_key_parser.sv @@
// ----------------------------------------------------------------------------
// tb_ansi_escape_key_parser: self-checking bench for the escape-key parser
// Walks a table of hand-picked bytes, then random streams built from arrow,
// function-key, broken and plain sequences under several quit bytes. Results
// are checked against a bit-exact predictor of the parser or a typed-in row.
// ----------------------------------------------------------------------------
module tb_ansi_escape_key_parser;
    import aekp_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 8;       // settle time for decode plus queue slack
    localparam int LONG_HOLD    = 80;      // receiver hold-off, in cycles
    localparam int PHASE_ITEMS  = 55;
    localparam int QUIT_PHASES  = 7;
    localparam int RUN_LIMIT    = 4_000_000;
    localparam int DIR_ROWS     = 25;

    localparam logic [3:0] KEY_LEFT = 4'd3;

    // One result of the parser, as it leaves the output channel.
    typedef struct packed {
        kind_t      kind;
        logic [7:0] plain;
        logic [3:0] code;
        logic       last;
    } key_rec_t;

    // One row of the directed table: the byte and, where typed in, its result.
    typedef struct packed {
        logic [7:0] data;
        logic       typed;
        key_rec_t   want;
    } dir_row_t;

    localparam key_rec_t NO_REC = '0;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [7:0] quit_byte;
    logic       in_valid;
    logic       in_ready;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_ready;
    logic [1:0] kind;
    logic [7:0] plain_byte;
    logic [3:0] key_code;
    logic       last;

    // Predictor copy of the parser state and of the quit register.
    state_t     pstate;
    logic [6:0] pnum;
    logic [7:0] quit_cfg;

    key_rec_t   expected_keys[$];    // results still owed by the parser
    logic [7:0] stream_q[$];         // bytes of the token being sent
    int         mismatch_count;
    int         burst_left;
    bit         long_hold_req;

    // Directed table. Typed rows carry the result that can be read off
    // directly; the rest are predicted.
    dir_row_t dir_table [DIR_ROWS] = '{
        '{8'h00,     1'b1, '{KIND_PLAIN, 8'h00, 4'd0, 1'b1}},
        '{8'hFF,     1'b1, '{KIND_PLAIN, 8'hFF, 4'd0, 1'b1}},
        '{QUIT_RESET,1'b1, '{KIND_QUIT,  8'h00, 4'd0, 1'b1}},
        '{CH_ESC,    1'b0, NO_REC},
        '{CH_LBRACK, 1'b0, NO_REC},
        '{CH_D,      1'b1, '{KIND_KEY, 8'h00, KEY_LEFT, 1'b1}},
        '{CH_ESC,    1'b0, NO_REC},
        '{CH_SS3,    1'b0, NO_REC},
        '{CH_P,      1'b1, '{KIND_KEY, 8'h00, KEY_F1, 1'b1}},
        '{CH_ESC,    1'b0, NO_REC},
        '{CH_LBRACK, 1'b0, NO_REC},
        '{8'h32,     1'b0, NO_REC},
        '{8'h34,     1'b0, NO_REC},
        '{CH_TILDE,  1'b1, '{KIND_KEY, 8'h00, KEY_F12, 1'b1}},
        // saturating number, then a break: the longest flush
        '{CH_ESC,    1'b0, NO_REC},
        '{CH_LBRACK, 1'b0, NO_REC},
        '{CH_NINE,   1'b0, NO_REC},
        '{CH_NINE,   1'b0, NO_REC},
        '{CH_NINE,   1'b0, NO_REC},
        '{8'h3B,     1'b0, NO_REC},
        // quit in the middle of a number leaves the number standing
        '{CH_ESC,    1'b0, NO_REC},
        '{CH_LBRACK, 1'b0, NO_REC},
        '{8'h31,     1'b0, NO_REC},
        '{QUIT_RESET,1'b1, '{KIND_QUIT,  8'h00, 4'd0, 1'b1}},
        '{CH_ESC,    1'b0, NO_REC}
    };

    logic [7:0] quit_plan [QUIT_PHASES] = '{
        8'h00, 8'hFF, CH_ESC, CH_LBRACK, 8'h35, 8'h00, QUIT_RESET
    };

    ansi_escape_key_parser u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .quit_byte  (quit_byte),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .plain_byte (plain_byte),
        .key_code   (key_code),
        .last       (last)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic key_rec_t make_rec(input kind_t k, input logic [7:0] p,
                                          input logic [3:0] c);
        key_rec_t r;
        r.kind  = k;
        r.plain = p;
        r.code  = c;
        r.last  = 1'b0;
        return r;
    endfunction

    // Function key for the number of an ESC [ n ~ sequence; -1 when unknown.
    function automatic int fkey_for_number(input int n);
        if (n >= 11 && n <= 15)
        begin
            return n - 11 + 4;
        end
        if (n >= 17 && n <= 21)
        begin
            return n - 17 + 9;
        end
        if (n == 23)
        begin
            return 14;
        end
        if (n == 24)
        begin
            return 15;
        end
        return -1;
    endfunction

    // Advance the predictor by one accepted byte and queue the results it
    // owes, with last set on the final one.
    function automatic void predict_keys(input logic [7:0] b);
        key_rec_t outs[$];
        logic     is_digit;
        int       acc;
        int       fk;
        is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        if (b == quit_cfg)
        begin
            // quit wins in every state and leaves the state alone
            outs = {outs, make_rec(KIND_QUIT, 8'h00, 4'd0)};
        end
        else
        begin
            case (pstate)
                ST_ESC:
                begin
                    if (b == CH_LBRACK)
                    begin
                        pstate = ST_CSI;
                    end
                    else if (b == CH_SS3)
                    begin
                        pstate = ST_SS3;
                    end
                    else
                    begin
                        pstate = ST_IDLE;
                        outs = {outs, make_rec(KIND_PLAIN, CH_ESC, 4'd0)};
                        outs = {outs, make_rec(KIND_PLAIN, b, 4'd0)};
                    end
                end
                ST_CSI:
                begin
                    if (b >= CH_A && b <= CH_D)
                    begin
                        pstate = ST_IDLE;
                        outs = {outs, make_rec(KIND_KEY, 8'h00, 4'(b - CH_A))};
                    end
                    else if (is_digit)
                    begin
                        pnum   = 7'(b - CH_ZERO);
                        pstate = ST_NUM;
                    end
                    else
                    begin
                        pstate = ST_IDLE;
                        outs = {outs, make_rec(KIND_PLAIN, CH_ESC, 4'd0)};
                        outs = {outs, make_rec(KIND_PLAIN, CH_LBRACK, 4'd0)};
                        outs = {outs, make_rec(KIND_PLAIN, b, 4'd0)};
                    end
                end
                ST_NUM:
                begin
                    acc = int'(pnum);
                    if (acc > 99)
                    begin
                        acc = 99;
                    end
                    if (is_digit)
                    begin
                        acc = acc * 10 + int'(b - CH_ZERO);
                        if (acc > 99)
                        begin
                            acc = 99;
                        end
                        pnum = 7'(acc);
                    end
                    else if (b == CH_TILDE)
                    begin
                        pstate = ST_IDLE;
                        fk = fkey_for_number(acc);
                        if (fk >= 0)
                        begin
                            outs = {outs, make_rec(KIND_KEY, 8'h00, 4'(fk))};
                        end
                    end
                    else
                    begin
                        // flush ESC [ and the number as digits, then the byte
                        pstate = ST_IDLE;
                        outs = {outs, make_rec(KIND_PLAIN, CH_ESC, 4'd0)};
                        outs = {outs, make_rec(KIND_PLAIN, CH_LBRACK, 4'd0)};
                        if (acc >= 10)
                        begin
                            outs = {outs, make_rec(KIND_PLAIN, 8'(CH_ZERO + acc / 10), 4'd0)};
                        end
                        outs = {outs, make_rec(KIND_PLAIN, 8'(CH_ZERO + acc % 10), 4'd0)};
                        outs = {outs, make_rec(KIND_PLAIN, b, 4'd0)};
                    end
                end
                ST_SS3:
                begin
                    pstate = ST_IDLE;
                    if (b >= CH_P && b <= CH_S)
                    begin
                        outs = {outs, make_rec(KIND_KEY, 8'h00, KEY_F1 + 4'(b - CH_P))};
                    end
                    else
                    begin
                        outs = {outs, make_rec(KIND_PLAIN, CH_ESC, 4'd0)};
                        outs = {outs, make_rec(KIND_PLAIN, CH_SS3, 4'd0)};
                        outs = {outs, make_rec(KIND_PLAIN, b, 4'd0)};
                    end
                end
                default:
                begin
                    pstate = ST_IDLE;
                    if (b == CH_ESC)
                    begin
                        pstate = ST_ESC;
                    end
                    else
                    begin
                        outs = {outs, make_rec(KIND_PLAIN, b, 4'd0)};
                    end
                end
            endcase
        end
        foreach (outs[i])
        begin
            if (i == outs.size() - 1)
            begin
                outs[i].last = 1'b1;
            end
            expected_keys = {expected_keys, outs[i]};
        end
    endfunction

    // ------------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------------

    // Offer one byte request and hold it until accepted, then predict it.
    // Between bursts, drop valid for a random gap.
    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input key_rec_t want);
        int pre;
        in_valid <= 1'b1;
        in_byte  <= b;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pre = expected_keys.size();
        predict_keys(b);
        if (typed)
        begin
            // the typed-in result replaces the prediction for this row
            while (expected_keys.size() > pre)
            begin
                void'(expected_keys.pop_back());
            end
            expected_keys = {expected_keys, want};
        end
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            // mostly short bursts, now and then a long back-to-back stretch
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(0, 12);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    // Wait until every owed result has come out, then let the pipe settle:
    // a byte that yields nothing may still be in flight.
    task automatic wait_drained();
        while (expected_keys.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_quit(input logic [7:0] v);
        cfg_valid <= 1'b1;
        quit_byte <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        quit_cfg = v;
        cfg_valid <= 1'b0;
    endtask

    // Queue the decimal digits of n, without leading zeros.
    function automatic void push_number(input int n);
        if (n >= 100)
        begin
            stream_q = {stream_q, 8'(CH_ZERO + n / 100)};
        end
        if (n >= 10)
        begin
            stream_q = {stream_q, 8'(CH_ZERO + (n / 10) % 10)};
        end
        stream_q = {stream_q, 8'(CH_ZERO + n % 10)};
    endfunction

    // Build one token of the terminal stream: mostly well-formed sequences
    // with random content, the rest broken sequences and noise.
    task automatic build_token();
        int sel;
        int idx;
        int n;
        sel = $urandom_range(0, 99);
        if (sel < 25)
        begin
            stream_q = {stream_q, 8'($urandom_range(0, 255))};
        end
        else if (sel < 42)
        begin
            stream_q = {stream_q, CH_ESC};
            stream_q = {stream_q, CH_LBRACK};
            stream_q = {stream_q, CH_A + 8'($urandom_range(0, 3))};
        end
        else if (sel < 54)
        begin
            stream_q = {stream_q, CH_ESC};
            stream_q = {stream_q, CH_SS3};
            stream_q = {stream_q, CH_P + 8'($urandom_range(0, 3))};
        end
        else if (sel < 76)
        begin
            // ESC [ n ~ : mostly known numbers, some unknown or saturating
            idx = $urandom_range(0, 99);
            if (idx < 60)
            begin
                n = $urandom_range(0, 11);
                n = (n < 5) ? 11 + n : (n < 10) ? 12 + n : (n == 10) ? 23 : 24;
            end
            else if (idx < 85)
            begin
                n = $urandom_range(0, 30);
            end
            else
            begin
                n = $urandom_range(0, 999);
            end
            stream_q = {stream_q, CH_ESC};
            stream_q = {stream_q, CH_LBRACK};
            push_number(n);
            stream_q = {stream_q, CH_TILDE};
        end
        else if (sel < 92)
        begin
            // break a sequence off with a random byte
            stream_q = {stream_q, CH_ESC};
            case ($urandom_range(0, 3))
                0:
                begin
                end
                1:
                begin
                    stream_q = {stream_q, CH_LBRACK};
                end
                2:
                begin
                    stream_q = {stream_q, CH_LBRACK};
                    push_number($urandom_range(0, 150));
                end
                default:
                begin
                    stream_q = {stream_q, CH_SS3};
                end
            endcase
            stream_q = {stream_q, 8'($urandom_range(0, 255))};
        end
        else
        begin
            stream_q = {stream_q, CH_ESC};
        end
        // drop the quit byte into the token now and then
        if ($urandom_range(0, 11) == 0)
        begin
            idx = $urandom_range(0, stream_q.size());
            stream_q.insert(idx, quit_cfg);
        end
    endtask

    task automatic run_phase(input int count);
        int sent;
        sent = 0;
        while (sent < count)
        begin
            build_token();
            while (stream_q.size() != 0)
            begin
                send_byte(stream_q[0], 1'b0, NO_REC);
                stream_q.delete(0);
                sent++;
            end
        end
        in_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n         <= 1'b0;
        cfg_valid     <= 1'b0;
        quit_byte     <= 8'h00;
        in_valid      <= 1'b0;
        in_byte       <= 8'h00;
        pstate         = ST_IDLE;
        pnum           = 7'd0;
        quit_cfg       = QUIT_RESET;
        mismatch_count = 0;
        burst_left     = 0;
        long_hold_req  = 1'b0;
        quit_plan[5]   = 8'($urandom_range(0, 255));

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part, under the reset quit byte
        foreach (dir_table[i])
        begin
            send_byte(dir_table[i].data, dir_table[i].typed, dir_table[i].want);
        end
        in_valid <= 1'b0;

        // random part: one phase per quit byte, written only once drained
        for (int p = 0; p < QUIT_PHASES; p++)
        begin
            wait_drained();
            write_quit(quit_plan[p]);
            if (p == 0 || p == 3)
            begin
                long_hold_req = 1'b1;
            end
            run_phase(PHASE_ITEMS);
        end

        wait_drained();
        if (mismatch_count == 0)
        begin
            $display("tb_ansi_escape_key_parser OK");
        end
        else
        begin
            $display("tb_ansi_escape_key_parser NOT OK");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall on a rotating pattern, and on request hold off for a
    // long stretch so the result queue fills and the input backs up.
    // ------------------------------------------------------------------------
    initial
    begin
        int cyc;
        int hold;
        cyc  = 0;
        hold = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            cyc++;
            if (long_hold_req && hold == 0)
            begin
                hold          = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                case ((cyc / 48) % 4)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= 1'($urandom_range(0, 1));
                    2:       out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= (cyc % 5 != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checker: compare each accepted result with the oldest owed one.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        key_rec_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_keys.size() == 0)
            begin
                $error("unexpected result: kind %0d plain_byte %02h key_code %0d last %0b",
                       kind, plain_byte, key_code, last);
                mismatch_count++;
            end
            else
            begin
                want = expected_keys[0];
                expected_keys.delete(0);
                if (kind !== want.kind)
                begin
                    $error("kind: expected %0d, got %0d", want.kind, kind);
                    mismatch_count++;
                end
                if (plain_byte !== want.plain)
                begin
                    $error("plain_byte: expected %02h, got %02h", want.plain, plain_byte);
                    mismatch_count++;
                end
                if (key_code !== want.code)
                begin
                    $error("key_code: expected %0d, got %0d", want.code, key_code);
                    mismatch_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0b, got %0b", want.last, last);
                    mismatch_count++;
                end
            end
        end
    end

    // Hard stop in case the handshakes hang.
    initial
    begin
        #(RUN_LIMIT);
        $display("tb_ansi_escape_key_parser NOT OK");
        $finish;
    end

endmodule
